[rtl/cia_pkg.sv]
// Package for the checked integer ALU: opcodes, status codes, transaction
// structs and the queue entry type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cia_pkg;

    typedef enum logic [3:0] {
        OP_ADD32  = 4'd0,
        OP_SUB32  = 4'd1,
        OP_MUL32  = 4'd2,
        OP_DIV32  = 4'd3,
        OP_MOD32  = 4'd4,
        OP_NEG32  = 4'd5,
        OP_ABS32  = 4'd6,
        OP_ADD64  = 4'd7,
        OP_SUB64  = 4'd8,
        OP_MUL64  = 4'd9,
        OP_DIV64  = 4'd10,
        OP_MOD64  = 4'd11,
        OP_NEG64  = 4'd12,
        OP_NARROW = 4'd13
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_UNF  = 2'd2,
        ST_DIVZ = 2'd3
    } status_t;

    // Work class decided by the front end
    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MUL  = 2'd1,
        S_DIV  = 2'd2
    } back_state_t;

    localparam int MulSteps = 4;
    localparam int DivSteps = 64;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } request_t;

    typedef struct packed {
        logic signed [63:0] value;
        logic [1:0]         status;
    } response_t;

    // One classified transaction waiting for the back end
    typedef struct packed {
        kind_t              kind;
        logic               wide;     // 64-bit multiply
        logic               is_mod;   // remainder wanted
        logic signed [63:0] a;        // effective operands
        logic signed [63:0] b;
        logic signed [63:0] value;    // finished result for simple ops
        logic [1:0]         status;
    } entry_t;

endpackage
`default_nettype wire

[rtl/checked_integer_alu.sv]
// Checked integer ALU top level: front end, two-entry queue, back end.
// Add/sub/neg/abs/narrow and trapped ops: one per cycle while the back end is idle.
// Multiply: serial 32x32 partial products; the back end takes no new transaction until it is done.
// Divide/modulo: one quotient bit a cycle; the back end likewise takes nothing new until it is done.
// Reset clears queue and sequencer; the receiver cannot stall, done pulses.
// Depends on cia_pkg, cia_front, cia_queue, cia_back.
`timescale 1ns / 1ps
`default_nettype none
module checked_integer_alu
    import cia_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  request_t  request,
    output logic      done,
    output response_t response
);

    entry_t front_ent, head;
    logic   q_full, q_valid, q_pop;

    // Classify the transaction and finish the simple ops up front
    cia_front u_front (
        .req (request),
        .ent (front_ent)
    );

    // Hold classified transactions while the back end is iterating
    cia_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !busy),
        .push_data (front_ent),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head)
    );

    // Accept a new transaction whenever the queue has room
    assign busy = q_full;

    // Execute in order: multiply and divide sequencers, result register
    cia_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_head  (head),
        .q_pop   (q_pop),
        .done    (done),
        .result  (response)
    );

endmodule
`default_nettype wire

[rtl/cia_front.sv]
// Front end: decodes a request, finishes simple ops and flags traps.
// Depends on cia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cia_front
    import cia_pkg::*;
(
    input  request_t req,
    output entry_t   ent
);

    logic signed [63:0] a32, b32, a64, b64, sum32, dif32;
    logic        [64:0] sum64, dif64;
    logic               a32_min, a64_min, b32_zero, b64_zero, b32_m1, b64_m1;

    assign a64      = req.operand_a;
    assign b64      = req.operand_b;
    assign a32      = {{32{req.operand_a[31]}}, req.operand_a[31:0]};
    assign b32      = {{32{req.operand_b[31]}}, req.operand_b[31:0]};
    assign sum32    = a32 + b32;
    assign dif32    = a32 - b32;
    assign sum64    = {a64[63], a64} + {b64[63], b64};
    assign dif64    = {a64[63], a64} - {b64[63], b64};
    assign a32_min  = (req.operand_a[31:0] == 32'h8000_0000);
    assign a64_min  = (a64 == {1'b1, 63'd0});
    assign b32_zero = (req.operand_b[31:0] == 32'd0);
    assign b64_zero = (b64 == 64'd0);
    assign b32_m1   = (req.operand_b[31:0] == 32'hFFFF_FFFF);
    assign b64_m1   = (b64 == {64{1'b1}});

    function automatic logic [1:0] range32(input logic signed [63:0] r);
        if (r[63:31] == {33{1'b0}} || r[63:31] == {33{1'b1}})
            return ST_OK;
        return r[63] ? ST_UNF : ST_OVF;
    endfunction

    always_comb
    begin
        ent        = '0;
        ent.kind   = K_SIMPLE;
        ent.status = ST_OK;
        ent.a      = a32;
        ent.b      = b32;
        unique case (req.op)
            OP_ADD32:
            begin
                ent.status = range32(sum32);
                if (ent.status == ST_OK)
                    ent.value = sum32;
            end
            OP_SUB32:
            begin
                ent.status = range32(dif32);
                if (ent.status == ST_OK)
                    ent.value = dif32;
            end
            OP_MUL32:
                ent.kind = K_MUL;
            OP_MUL64:
            begin
                ent.kind = K_MUL;
                ent.wide = 1'b1;
                ent.a    = a64;
                ent.b    = b64;
            end
            OP_DIV32, OP_MOD32:
            begin
                ent.is_mod = (req.op == OP_MOD32);
                if (b32_zero)
                    ent.status = ST_DIVZ;
                else if (a32_min && b32_m1)
                    ent.status = ST_OVF;
                else
                    ent.kind = K_DIV;
            end
            OP_DIV64, OP_MOD64:
            begin
                ent.is_mod = (req.op == OP_MOD64);
                ent.a      = a64;
                ent.b      = b64;
                if (b64_zero)
                    ent.status = ST_DIVZ;
                else if (a64_min && b64_m1)
                    ent.status = ST_OVF;
                else
                    ent.kind = K_DIV;
            end
            OP_NEG32:
            begin
                if (a32_min)
                    ent.status = ST_OVF;
                else
                    ent.value = -a32;
            end
            OP_ABS32:
            begin
                if (a32_min)
                    ent.status = ST_OVF;
                else
                    ent.value = a32[63] ? -a32 : a32;
            end
            OP_ADD64:
            begin
                if (sum64[64:63] == 2'b01)
                    ent.status = ST_OVF;
                else if (sum64[64:63] == 2'b10)
                    ent.status = ST_UNF;
                else
                    ent.value = sum64[63:0];
            end
            OP_SUB64:
            begin
                if (dif64[64:63] == 2'b01)
                    ent.status = ST_OVF;
                else if (dif64[64:63] == 2'b10)
                    ent.status = ST_UNF;
                else
                    ent.value = dif64[63:0];
            end
            OP_NEG64:
            begin
                if (a64_min)
                    ent.status = ST_OVF;
                else
                    ent.value = -a64;
            end
            OP_NARROW:
            begin
                if (a64[63:31] == {33{1'b0}} || a64[63:31] == {33{1'b1}})
                    ent.value = a64;
                else
                    ent.status = ST_OVF;
            end
            default:
                ent.value = '0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/cia_queue.sv]
// Two-entry queue between front and back end.
// Depends on cia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cia_queue
    import cia_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output entry_t head
);

    entry_t     slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

[rtl/cia_back.sv]
// Back end: sequential 64x64 multiply (four 32x32 partial products) and
// radix-2 restoring divide; simple results pass straight to the output.
// Depends on cia_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cia_back
    import cia_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  entry_t    q_head,
    output logic      q_pop,
    output logic      done,
    output response_t result
);

    back_state_t state_reg, state_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [63:0]  x_reg, x_next, y_reg, y_next;
    logic [63:0]  pp_reg, pp_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  rem_reg, rem_next;
    logic         neg_reg, neg_next, rneg_reg, rneg_next;
    logic         wide_reg, wide_next, mod_reg, mod_next;
    logic         done_reg, done_next;
    response_t    res_reg, res_next;

    logic [2:0]   prev_idx;
    logic [127:0] pp_shifted;
    logic [64:0]  trial;
    logic [63:0]  lo, qv, rv;
    logic         fits;

    assign done     = done_reg;
    assign result   = res_reg;
    assign prev_idx = cnt_reg[2:0] - 3'd1;

    always_comb
    begin
        case ({1'b0, prev_idx[1]} + {1'b0, prev_idx[0]})
            2'd0:    pp_shifted = {64'd0, pp_reg};
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            default: pp_shifted = {pp_reg, 64'd0};
        endcase
    end

    assign trial = {rem_reg, x_reg[63]} - {1'b0, y_reg};
    assign lo    = acc_reg[63:0];
    assign qv    = neg_reg ? -x_reg : x_reg;
    assign rv    = rneg_reg ? -rem_reg : rem_reg;

    always_comb
    begin
        if (wide_reg)
            fits = (acc_reg[127:64] == 64'd0) &&
                   (neg_reg ? (lo <= {1'b1, 63'd0}) : !lo[63]);
        else
            fits = (acc_reg[127:32] == 96'd0) &&
                   (neg_reg ? (lo[31:0] <= 32'h8000_0000) : !lo[31]);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        pp_next    = pp_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        rneg_next  = rneg_reg;
        wide_next  = wide_reg;
        mod_next   = mod_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        q_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    x_next    = q_head.a[63] ? -q_head.a : q_head.a;
                    y_next    = q_head.b[63] ? -q_head.b : q_head.b;
                    neg_next  = q_head.a[63] ^ q_head.b[63];
                    rneg_next = q_head.a[63];
                    wide_next = q_head.wide;
                    mod_next  = q_head.is_mod;
                    cnt_next  = '0;
                    acc_next  = '0;
                    rem_next  = '0;
                    case (q_head.kind)
                        K_MUL:   state_next = S_MUL;
                        K_DIV:   state_next = S_DIV;
                        default:
                        begin
                            res_next.value  = q_head.value;
                            res_next.status = q_head.status;
                            done_next       = 1'b1;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                // issue one partial product, accumulate the previous one
                pp_next = 64'((cnt_reg[1] ? x_reg[63:32] : x_reg[31:0]) *
                              (cnt_reg[0] ? y_reg[63:32] : y_reg[31:0]));
                if (cnt_reg != 7'd0)
                    acc_next = acc_reg + pp_shifted;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(MulSteps + 1))
                begin
                    res_next.value  = fits ? (neg_reg ? -lo : lo) : 64'd0;
                    res_next.status = fits ? ST_OK : ST_OVF;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == 7'(DivSteps))
                begin
                    res_next.value  = mod_reg ? rv : qv;
                    res_next.status = ST_OK;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    // shift in one dividend bit, keep difference if no borrow
                    if (!trial[64])
                        rem_next = trial[63:0];
                    else
                        rem_next = {rem_reg[62:0], x_reg[63]};
                    x_next   = {x_reg[62:0], ~trial[64]};
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        pp_reg   <= pp_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        neg_reg  <= neg_next;
        rneg_reg <= rneg_next;
        wide_reg <= wide_next;
        mod_reg  <= mod_next;
        res_reg  <= res_next;
    end

endmodule
`default_nettype wire
